FILE: rtl/fvn_pkg.sv
// Package for the fixed-point vector normalizer.
// Holds field widths and the saturating magnitude helper; no dependencies.
package fvn_pkg;

  localparam int IN_W  = 32;  // input component width
  localparam int OUT_W = 18;  // result component width
  localparam int MAG_W = 31;  // saturated magnitude width

  // Magnitude of a component, with the most negative value saturated.
  function automatic logic [MAG_W-1:0] sat_mag(input logic signed [IN_W-1:0] v);
    logic [IN_W-1:0] a;
    begin
      a = v[IN_W-1] ? (~v + IN_W'(1)) : v;
      if (a[IN_W-1]) begin
        sat_mag = {MAG_W{1'b1}};
      end else begin
        sat_mag = a[MAG_W-1:0];
      end
    end
  endfunction

endpackage

FILE: rtl/fvn_if.sv
// Channel interfaces of the vector normalizer: input and result words.
// Depends on fvn_pkg for the field widths.
interface fvn_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [fvn_pkg::IN_W-1:0]  x_in;
  logic signed [fvn_pkg::IN_W-1:0]  y_in;
  logic signed [fvn_pkg::IN_W-1:0]  z_in;
  modport source(output valid, x_in, y_in, z_in, input ready);
  modport sink(input valid, x_in, y_in, z_in, output ready);
endinterface

interface fvn_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [fvn_pkg::OUT_W-1:0] x_out;
  logic signed [fvn_pkg::OUT_W-1:0] y_out;
  logic signed [fvn_pkg::OUT_W-1:0] z_out;
  logic                             zero_length;
  modport source(output valid, x_out, y_out, z_out, zero_length, input ready);
  modport sink(input valid, x_out, y_out, z_out, zero_length, output ready);
endinterface

FILE: rtl/fvn_front.sv
// Front end: takes an input word and scales it down one bit per cycle.
// Depends on fvn_pkg and fvn_in_if.
module fvn_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  fvn_in_if.sink                  in_vec,
  output logic                    push_valid,
  input  logic                    push_ready,
  output logic [3*(FRAC_BITS+1)-1:0] push_data
);

  localparam int CW = FRAC_BITS + 1;
  localparam logic [fvn_pkg::MAG_W-1:0] HALF = fvn_pkg::MAG_W'(1) << (FRAC_BITS - 1);
  localparam logic F_IDLE  = 1'b0;
  localparam logic F_SHIFT = 1'b1;

  logic                           state_r, state_nxt;
  logic signed [fvn_pkg::IN_W-1:0] x_r, y_r, z_r;
  logic [fvn_pkg::MAG_W-1:0]      mx_r;
  logic [fvn_pkg::MAG_W-1:0]      mx0, mx1, mx2, mx01, mx_in;
  logic                           big;

  assign mx0   = fvn_pkg::sat_mag(in_vec.x_in);
  assign mx1   = fvn_pkg::sat_mag(in_vec.y_in);
  assign mx2   = fvn_pkg::sat_mag(in_vec.z_in);
  assign mx01  = (mx1 > mx0) ? mx1 : mx0;
  assign mx_in = (mx2 > mx01) ? mx2 : mx01;

  assign big          = (mx_r >= HALF);
  assign in_vec.ready = (state_r == F_IDLE);
  assign push_valid   = (state_r == F_SHIFT) && !big;
  assign push_data    = {x_r[CW-1:0], y_r[CW-1:0], z_r[CW-1:0]};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: begin
        if (in_vec.valid) state_nxt = F_SHIFT;
      end
      F_SHIFT: begin
        if (!big && push_ready) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    if (in_vec.valid && in_vec.ready) begin
      x_r  <= in_vec.x_in;
      y_r  <= in_vec.y_in;
      z_r  <= in_vec.z_in;
      mx_r <= mx_in;
    end else if (state_r == F_SHIFT && big) begin
      x_r  <= x_r >>> 1;
      y_r  <= y_r >>> 1;
      z_r  <= z_r >>> 1;
      mx_r <= mx_r >> 1;
    end
  end

endmodule

FILE: rtl/fvn_queue.sv
// Two-entry queue between the front end and the back end.
// Depends on nothing but its width parameter.
module fvn_queue #(
  parameter int W = 51
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r, rd_ptr_r;
  logic [1:0]   count_r;
  logic         do_wr, do_rd;

  assign wr_ready = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr_r <= ~wr_ptr_r;
      if (do_rd) rd_ptr_r <= ~rd_ptr_r;
      if (do_wr && !do_rd) begin
        count_r <= count_r + 2'd1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 2'd1;
      end
    end
    if (do_wr) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

FILE: rtl/fvn_back.sv
// Back end: sum of squares, iterative square root, three divider lanes.
// Depends on fvn_pkg and fvn_out_if.
module fvn_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        pop_valid,
  output logic                        pop_ready,
  input  logic [3*(FRAC_BITS+1)-1:0]  pop_data,
  fvn_out_if.source                   out_vec
);

  localparam int CW = FRAC_BITS + 1;    // scaled signed component
  localparam int MW = FRAC_BITS;        // component magnitude
  localparam int SW = 2 * FRAC_BITS;    // sum of squares
  localparam int QW = FRAC_BITS + 1;    // quotient
  localparam int NW = $clog2(FRAC_BITS + 2);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_SQ   = 3'd1;
  localparam logic [2:0] B_SQRT = 3'd2;
  localparam logic [2:0] B_LEN  = 3'd3;
  localparam logic [2:0] B_DIV  = 3'd4;
  localparam logic [2:0] B_FIN  = 3'd5;
  localparam logic [2:0] B_OUT  = 3'd6;

  logic [2:0]           state_r, state_nxt;
  logic signed [CW-1:0] c_r [3];
  logic [1:0]           idx_r;
  logic [NW-1:0]        cnt_r;
  logic [SW-1:0]        acc_r, res_r, bit_r;
  logic [MW-1:0]        len_r;
  logic [MW-1:0]        rem_r [3];
  logic [QW-1:0]        nb_r [3];
  logic [QW-1:0]        q_r [3];
  logic [MW-1:0]        mag [3];
  logic [MW-1:0]        sq_mag;
  logic [SW-1:0]        sq_prod;
  logic [SW:0]          trial;
  logic [QW-1:0]        rem2 [3];
  logic                 ge [3];
  logic signed [QW:0]   sval [3];
  logic signed [31:0]   wide [3];
  logic signed [fvn_pkg::OUT_W-1:0] ox_r, oy_r, oz_r;
  logic                 ozero_r, ovalid_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i]  = c_r[i][CW-1] ? MW'(-c_r[i]) : MW'(c_r[i]);
      rem2[i] = {rem_r[i], nb_r[i][QW-1]};
      ge[i]   = (rem2[i] >= {1'b0, len_r});
      sval[i] = c_r[i][CW-1] ? -$signed({1'b0, q_r[i]}) : $signed({1'b0, q_r[i]});
      wide[i] = 32'(sval[i]);
    end
  end

  assign sq_mag  = (idx_r == 2'd0) ? mag[0] : (idx_r == 2'd1) ? mag[1] : mag[2];
  assign sq_prod = sq_mag * sq_mag;
  assign trial   = {1'b0, res_r} + {1'b0, bit_r};

  assign pop_ready = (state_r == B_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (pop_valid) state_nxt = B_SQ;
      B_SQ:   if (idx_r == 2'd2) state_nxt = B_SQRT;
      B_SQRT: if (cnt_r == NW'(FRAC_BITS - 1)) state_nxt = B_LEN;
      B_LEN:  state_nxt = (res_r == '0) ? B_OUT : B_DIV;
      B_DIV:  if (cnt_r == NW'(QW - 1)) state_nxt = B_FIN;
      B_FIN:  state_nxt = B_OUT;
      B_OUT:  if (out_vec.ready) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == B_LEN && res_r == '0) || state_r == B_FIN) begin
        ovalid_r <= 1'b1;
      end else if (state_r == B_OUT && out_vec.ready) begin
        ovalid_r <= 1'b0;
      end
    end
    case (state_r)
      B_IDLE: begin
        c_r[0] <= pop_data[3*CW-1:2*CW];
        c_r[1] <= pop_data[2*CW-1:CW];
        c_r[2] <= pop_data[CW-1:0];
        idx_r  <= 2'd0;
        acc_r  <= '0;
      end
      B_SQ: begin
        acc_r <= acc_r + sq_prod;
        idx_r <= idx_r + 2'd1;
        res_r <= '0;
        bit_r <= SW'(1) << (SW - 2);
        cnt_r <= '0;
      end
      B_SQRT: begin
        if ({1'b0, acc_r} >= trial) begin
          acc_r <= acc_r - trial[SW-1:0];
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r + NW'(1);
      end
      B_LEN: begin
        len_r <= res_r[MW-1:0];
        cnt_r <= '0;
        for (int i = 0; i < 3; i++) begin
          // Upper numerator bits are known to be below the length.
          rem_r[i] <= MW'(mag[i] >> 1);
          nb_r[i]  <= {mag[i][0], {(QW-1){1'b0}}};
          q_r[i]   <= '0;
        end
        ox_r    <= '0;
        oy_r    <= '0;
        oz_r    <= '0;
        ozero_r <= (res_r == '0);
      end
      B_DIV: begin
        for (int i = 0; i < 3; i++) begin
          rem_r[i] <= ge[i] ? MW'(rem2[i] - {1'b0, len_r}) : rem2[i][MW-1:0];
          nb_r[i]  <= nb_r[i] << 1;
          q_r[i]   <= {q_r[i][QW-2:0], ge[i]};
        end
        cnt_r <= cnt_r + NW'(1);
      end
      B_FIN: begin
        ox_r <= wide[0][fvn_pkg::OUT_W-1:0];
        oy_r <= wide[1][fvn_pkg::OUT_W-1:0];
        oz_r <= wide[2][fvn_pkg::OUT_W-1:0];
      end
      default: begin
      end
    endcase
  end

  assign out_vec.valid       = ovalid_r;
  assign out_vec.x_out       = ox_r;
  assign out_vec.y_out       = oy_r;
  assign out_vec.z_out       = oz_r;
  assign out_vec.zero_length = ozero_r;

endmodule

FILE: rtl/fixed_point_vector_normalize.sv
// Fixed-point 3-D vector normalizer, top level.
// Depends on fvn_pkg, fvn_if, fvn_front, fvn_queue and fvn_back.
//
// The block takes a word of three signed 32-bit components with FRAC_BITS
// fractional bits and returns one word holding the unit vector as 18-bit
// signed components, plus a zero_length flag that is set, with all three
// components zero, when the input vector is zero. The front end scales the
// vector down by one arithmetic right shift per cycle until the largest
// magnitude is below one half, and then places it in a two-entry queue, so
// it can take the next word while the back end is still busy. The back end
// accumulates the three squares, runs a bit-serial binary square root at
// one result bit per cycle, checks the length for zero, and divides all
// three components in parallel lanes at one quotient bit per cycle. It then
// fixes the signs and presents the word; it takes a new word only when
// idle, after the previous result has been taken, and that loop sets the
// sustained rate. A zero vector skips the divisions and the sign fix-up.
// A finished word waits in the output register until it is taken.
module fixed_point_vector_normalize #(
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  fvn_in_if.sink     in_vec,
  fvn_out_if.source  out_vec
);

  localparam int QDW = 3 * (FRAC_BITS + 1);

  logic           fq_valid, fq_ready;
  logic [QDW-1:0] fq_data;
  logic           qb_valid, qb_ready;
  logic [QDW-1:0] qb_data;

  // Front end: capture and pre-scale.
  fvn_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vec     (in_vec),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data)
  );

  // Decoupling queue so each side stalls on its own.
  fvn_queue #(.W(QDW)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_data)
  );

  // Back end: length and the three divisions.
  fvn_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (qb_valid),
    .pop_ready (qb_ready),
    .pop_data  (qb_data),
    .out_vec   (out_vec)
  );

endmodule

FILE: rtl/fvn_checker.sv
// Port-level checks for the vector normalizer and their bind.
// Depends on fvn_pkg for widths; attaches to fixed_point_vector_normalize.
module fvn_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [fvn_pkg::OUT_W-1:0] x_out,
  input logic signed [fvn_pkg::OUT_W-1:0] y_out,
  input logic signed [fvn_pkg::OUT_W-1:0] z_out,
  input logic                             zero_length
);

  // A waiting result word must not change.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(x_out) && $stable(y_out)
      && $stable(z_out) && $stable(zero_length))
    else $error("result word changed while stalled");

  // A zero-length result carries zero components.
  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && zero_length |-> x_out == '0 && y_out == '0 && z_out == '0)
    else $error("zero_length set with nonzero components");

  // No result word appears right after reset.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind fixed_point_vector_normalize fvn_checker u_fvn_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_vec.valid),
  .out_ready   (out_vec.ready),
  .x_out       (out_vec.x_out),
  .y_out       (out_vec.y_out),
  .z_out       (out_vec.z_out),
  .zero_length (out_vec.zero_length)
);
